[rtl/bdeq_pkg.sv]
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared types and constants for the bounded double-ended queue.
// ----------------------------------------------------------------------------
package bdeq_pkg;

  // Ring geometry
  localparam int DEPTH  = 32;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = IDX_W + 1;

  // Command codes
  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_DUMP       = 3'd4
  } cmd_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_REMOVED  = 3'd1,
    ST_DUMPED   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_DUMP
  } state_t;

  // One result word handed from the sequencer to the output register
  typedef struct packed {
    logic               valid;
    status_t            status;
    logic signed [DATA_W-1:0] value;
    logic               last;
  } result_t;

endpackage

[rtl/bounded_double_ended_queue_unit.sv]
// ----------------------------------------------------------------------------
// bounded_double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit words on a ring buffer held
// in a single synchronous RAM.
// ----------------------------------------------------------------------------
// Commands are taken one at a time. For push front/back, and for any command
// that finds the queue full or empty, the result word is loaded into the
// output register at the accept edge. A pop reads the entry RAM at the accept
// edge; the registered RAM word is then loaded into the output register. A
// dump reads the front entry to start, then gives one dumped word per cycle
// while the output register is free, the final word flagged by last.
// Undefined command codes are taken and dropped with no result. Stall on the
// output side pauses the sequencer; a finished word waits in the output
// register while the next command is taken whenever that register is being
// drained. No clearing pass is run after reset.
// ----------------------------------------------------------------------------
module bounded_double_ended_queue_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         command,
  input  logic signed [bdeq_pkg::DATA_W-1:0] value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [2:0]                         status,
  output logic signed [bdeq_pkg::DATA_W-1:0] result_value,
  output logic                               last
);

  import bdeq_pkg::*;

  result_t           res;
  logic              out_free;
  logic              wr_en, rd_en;
  logic [IDX_W-1:0]  wr_addr, rd_addr;
  logic [DATA_W-1:0] wr_data, rd_data;

  // Command sequencer
  bdeq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .value    (value),
    .out_free (out_free),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // Entry store
  bdeq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (DATA_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result word register
  bdeq_out u_out (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .out_free     (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .result_value (result_value),
    .last         (last)
  );

endmodule

[rtl/bdeq_ram.sv]
// ----------------------------------------------------------------------------
// bdeq_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read word. The read word holds while rd_en is low.
// ----------------------------------------------------------------------------
module bdeq_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/bdeq_out.sv]
// ----------------------------------------------------------------------------
// bdeq_out
// Output register: holds one result word until the consumer takes it and
// tells the sequencer when a new word can be loaded.
// ----------------------------------------------------------------------------
module bdeq_out (
  input  logic                           clk,
  input  logic                           rst,
  input  bdeq_pkg::result_t              res,
  output logic                           out_free,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     status,
  output logic signed [bdeq_pkg::DATA_W-1:0] result_value,
  output logic                           last
);

  import bdeq_pkg::*;

  // Slot is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res.valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      status       <= res.status;
      result_value <= res.value;
      last         <= res.last;
    end
  end

endmodule

[rtl/bdeq_ctrl.sv]
// ----------------------------------------------------------------------------
// bdeq_ctrl
// Sequencer: keeps front index and fill count, decodes commands, drives the
// entry RAM and builds result words for the output register.
// ----------------------------------------------------------------------------
module bdeq_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [2:0]                         command,
  input  logic signed [bdeq_pkg::DATA_W-1:0] value,
  input  logic                               out_free,
  output bdeq_pkg::result_t                  res,
  output logic                               wr_en,
  output logic [bdeq_pkg::IDX_W-1:0]         wr_addr,
  output logic [bdeq_pkg::DATA_W-1:0]        wr_data,
  output logic                               rd_en,
  output logic [bdeq_pkg::IDX_W-1:0]         rd_addr,
  input  logic [bdeq_pkg::DATA_W-1:0]        rd_data
);

  import bdeq_pkg::*;

  state_t            state, state_next;
  logic [IDX_W-1:0]  front;
  logic [CNT_W-1:0]  count;
  logic [IDX_W-1:0]  idx;

  logic              accept;
  logic              full, empty;
  logic              dump_last;
  logic [IDX_W-1:0]  front_dec, front_inc;
  logic [IDX_W-1:0]  back_push, back_pop;

  // Ring position, wrapped by one compare and subtract
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  // Status and ring positions
  assign full      = (count == CNT_W'(DEPTH));
  assign empty     = (count == '0);
  assign front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : front - IDX_W'(1);
  assign front_inc = ring_pos(front, IDX_W'(1));
  assign back_push = ring_pos(front, count[IDX_W-1:0]);
  assign back_pop  = ring_pos(front, count[IDX_W-1:0] - IDX_W'(1));
  assign dump_last = (CNT_W'(idx) == count - CNT_W'(1));

  // New command only when idle and the output slot can take a word
  assign in_stall = !((state == S_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !empty) begin
          if (command == CMD_POP_FRONT || command == CMD_POP_BACK) begin
            state_next = S_POP;
          end else if (command == CMD_DUMP) begin
            state_next = S_DUMP;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_free && dump_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs: RAM access and result word
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = front_dec;
    wr_data = value;
    rd_en   = 1'b0;
    rd_addr = front;
    res     = '{valid: 1'b0, status: ST_INSERTED, value: '0, last: 1'b1};
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (full) begin
                res = '{valid: 1'b1, status: ST_FULL, value: value, last: 1'b1};
              end else begin
                wr_en   = 1'b1;
                wr_addr = (command == CMD_PUSH_FRONT) ? front_dec : back_push;
                res = '{valid: 1'b1, status: ST_INSERTED, value: value, last: 1'b1};
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK, CMD_DUMP: begin
              if (empty) begin
                res = '{valid: 1'b1, status: ST_EMPTY, value: '0, last: 1'b1};
              end else begin
                rd_en   = 1'b1;
                rd_addr = (command == CMD_POP_BACK) ? back_pop : front;
              end
            end
            default: ;  // undefined codes give nothing
          endcase
        end
      end
      S_POP: begin
        if (out_free) begin
          res = '{valid: 1'b1, status: ST_REMOVED, value: rd_data, last: 1'b1};
        end
      end
      S_DUMP: begin
        if (out_free) begin
          res = '{valid: 1'b1, status: ST_DUMPED, value: rd_data, last: dump_last};
          if (!dump_last) begin
            rd_en   = 1'b1;
            rd_addr = ring_pos(front, idx + IDX_W'(1));
          end
        end
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Ring pointers and dump walk index
  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
      idx   <= '0;
    end else begin
      if (accept) begin
        case (command)
          CMD_PUSH_FRONT: begin
            if (!full) begin
              front <= front_dec;
              count <= count + CNT_W'(1);
            end
          end
          CMD_PUSH_BACK: begin
            if (!full) begin
              count <= count + CNT_W'(1);
            end
          end
          CMD_POP_FRONT: begin
            if (!empty) begin
              front <= front_inc;
              count <= count - CNT_W'(1);
            end
          end
          CMD_POP_BACK: begin
            if (!empty) begin
              count <= count - CNT_W'(1);
            end
          end
          CMD_DUMP: idx <= '0;
          default: ;
        endcase
      end else if (state == S_DUMP && out_free && !dump_last) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

endmodule

[verif/bdeq_result_checker.sv]
// ----------------------------------------------------------------------------
// bdeq_result_checker
// Watches both channels of the double-ended queue. It keeps its own ring of
// entries, works out the words each accepted command must give and compares
// every word that leaves the block against the oldest one still due.
// ----------------------------------------------------------------------------
module bdeq_result_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [2:0]                         command,
  input  logic signed [bdeq_pkg::DATA_W-1:0] value,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic [2:0]                         status,
  input  logic signed [bdeq_pkg::DATA_W-1:0] result_value,
  input  logic                               last,
  output int                                 fail_count,
  output int                                 words_due
);

  import bdeq_pkg::*;

  typedef struct {
    status_t                  status;
    logic signed [DATA_W-1:0] data;
    logic                     last;
  } deque_word_t;

  // Shadow ring and the words still owed by the block
  logic signed [DATA_W-1:0] shadow_ring [DEPTH];
  int                       shadow_head = 0;
  int                       shadow_held = 0;
  deque_word_t              due_words [$];
  int                       fails = 0;
  int                       due_total = 0;

  assign fail_count = fails;
  assign words_due  = due_total;

  // Apply one command to the shadow ring and queue the words it must give
  function automatic void apply_command(input logic [2:0] cmd,
                                        input logic signed [DATA_W-1:0] data);
    int slot;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_held >= DEPTH) begin
          due_words.push_back('{ST_FULL, data, 1'b1});
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
            slot = shadow_head;
          end else begin
            slot = (shadow_head + shadow_held) % DEPTH;
          end
          shadow_ring[slot] = data;
          shadow_held++;
          due_words.push_back('{ST_INSERTED, data, 1'b1});
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (shadow_held == 0) begin
          due_words.push_back('{ST_EMPTY, '0, 1'b1});
        end else begin
          if (cmd == CMD_POP_FRONT) begin
            slot = shadow_head;
            shadow_head = (shadow_head + 1) % DEPTH;
          end else begin
            slot = (shadow_head + shadow_held - 1) % DEPTH;
          end
          shadow_held--;
          due_words.push_back('{ST_REMOVED, shadow_ring[slot], 1'b1});
        end
      end
      CMD_DUMP: begin
        if (shadow_held == 0) begin
          due_words.push_back('{ST_EMPTY, '0, 1'b1});
        end else begin
          for (int i = 0; i < shadow_held; i++) begin
            due_words.push_back('{ST_DUMPED, shadow_ring[(shadow_head + i) % DEPTH],
                                  (i + 1 == shadow_held)});
          end
        end
      end
      default: ; // undefined codes are swallowed
    endcase
  endfunction

  // Compare outgoing words first, then predict from the incoming one
  always @(posedge clk) begin
    deque_word_t want;
    if (rst) begin
      shadow_head = 0;
      shadow_held = 0;
      due_words.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_words.size() == 0) begin
          $error("result word with none due: status %0d value %0d last %0b",
                 status, result_value, last);
          fails++;
        end else begin
          want = due_words.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fails++;
          end
          if (result_value !== want.data) begin
            $error("result_value: expected %0d, actual %0d", want.data, result_value);
            fails++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, last);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_command(command, value);
      end
    end
    due_total = due_words.size();
  end

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives the double-ended queue with a short directed run covering empty,
// extreme and undefined commands, then biased random segments that fill the
// ring to overflow and drain it again, with random idling on both sides.
// The result checker beside the block does the predicting and comparing.
// ----------------------------------------------------------------------------
module testbench;
  import bdeq_pkg::*;

  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_MD = 3'd6;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  localparam int         QUIET_LIMIT = 2000;
  localparam int         SEG_WORDS   = 32;
  localparam int         SEG_COUNT   = 8;

  typedef enum int { MIX_FILL, MIX_DRAIN, MIX_EVEN } mix_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [2:0]               command = CMD_PUSH_BACK;
  logic signed [DATA_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [2:0]               status;
  logic signed [DATA_W-1:0] result_value;
  logic                     last;
  int                       fail_count;
  int                       words_due;

  bit gaps_on  = 1'b0;
  bit stalls_on = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  bounded_double_ended_queue_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .result_value(result_value), .last(last)
  );

  bdeq_result_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .result_value(result_value), .last(last),
    .fail_count(fail_count), .words_due(words_due)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(1, 17) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Present one command word and hold it until taken
  task automatic send_word(input logic [2:0] cmd, input logic signed [DATA_W-1:0] data);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    value    <= data;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold off the sender until every owed word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (words_due != 0);
    @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(DATA_W-1){1'b0}}};
      1:       return {1'b0, {(DATA_W-1){1'b1}}};
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_command(input mix_t mix);
    int roll;
    int push_pct;
    roll = $urandom_range(0, 99);
    push_pct = (mix == MIX_FILL) ? 92 : (mix == MIX_DRAIN) ? 12 : 50;
    if (roll < 3) return 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    if (roll < 11) return CMD_DUMP;
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end
    return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  initial begin
    mix_t seg_mix [SEG_COUNT];
    seg_mix = '{MIX_FILL, MIX_EVEN, MIX_DRAIN, MIX_FILL, MIX_FILL, MIX_EVEN, MIX_DRAIN,
                MIX_EVEN};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty cases, extreme values, undefined codes, drain to empty
    send_word(CMD_POP_FRONT, pick_value());
    send_word(CMD_POP_BACK, pick_value());
    send_word(CMD_DUMP, pick_value());
    send_word(CMD_PUSH_BACK, {1'b0, {(DATA_W-1){1'b1}}});
    send_word(CMD_PUSH_FRONT, {1'b1, {(DATA_W-1){1'b0}}});
    send_word(CMD_PUSH_BACK, '0);
    send_word(CMD_PUSH_FRONT, '1);
    send_word(CMD_PUSH_BACK, 32'h5555_5555);
    send_word(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_word(CMD_DUMP, '0);
    send_word(CMD_RSVD_LO, 32'h1234_5678);
    send_word(CMD_RSVD_MD, '1);
    send_word(CMD_RSVD_HI, '0);
    send_word(CMD_POP_FRONT, '1);
    send_word(CMD_POP_BACK, '1);
    send_word(CMD_DUMP, '1);
    repeat (4) send_word(CMD_POP_FRONT, pick_value());
    send_word(CMD_POP_BACK, pick_value());
    send_word(CMD_DUMP, pick_value());
    wait_drained();

    // Random segments; the last one starts no new gaps or stall bursts
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      gaps_on   = (seg != SEG_COUNT - 1) && ($urandom_range(0, 3) != 0);
      stalls_on = (seg != SEG_COUNT - 1) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < SEG_WORDS; n++) begin
        send_word(pick_command(seg_mix[seg]), pick_value());
      end
      if (seg == 2) wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
